FILE: hw/rtl/lshs_pkg.sv
package lshs_pkg;

    // default geometry
    localparam int L1_BITS_DEF = 16;
    localparam int I_BITS_DEF  = 16;

    // fixed field widths
    localparam int POS_W  = 32;
    localparam int PIDX_W = 16;
    localparam int HPOS_W = 16;

    // hit cap per prime
    localparam int MAX_HITS  = 64;
    localparam int HIT_CNT_W = $clog2(MAX_HITS + 1);

endpackage

FILE: hw/rtl/lattice_sieve_hit_scheduler.sv
// Channel   Dir  Handshake                 Payload
// in        in   in_valid / in_ready       vec0, vec1, start_position, prime_index, batch_end
// out       out  out_valid / out_ready     entry_prime_index, hit_position, hit_valid,
//                                          next_start, exceptional, last, batch_done
// cfg       in   cfg_wr_en (no wait)       cfg_wr_data -> oddness_type
//
// Sequence: one request goes through capture, v0+v1, start pick, bias and halve, then
//   one hit per cycle while the output register is free, then the closing result;
//   oddness type 0 skips start pick and bias and halve. Every step goes through the
//   single shared 32-bit adder.
// Reset: rst_n clears the sequencer, the output valid and oddness_type to 0.
// Stalls: a held output register halts the walk; in_ready is high only while idle,
//   and the final result of one request may wait while the next is taken.
module lattice_sieve_hit_scheduler
    import lshs_pkg::*;
#(
    parameter int L1_BITS = L1_BITS_DEF,
    parameter int I_BITS  = I_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_wr_data,

    input  logic              in_valid,
    output logic              in_ready,
    input  logic [POS_W-1:0]  vec0,
    input  logic [POS_W-1:0]  vec1,
    input  logic [POS_W-1:0]  start_position,
    input  logic [PIDX_W-1:0] prime_index,
    input  logic              batch_end,

    output logic              out_valid,
    input  logic              out_ready,
    output logic [PIDX_W-1:0] entry_prime_index,
    output logic [HPOS_W-1:0] hit_position,
    output logic              hit_valid,
    output logic [POS_W-1:0]  next_start,
    output logic              exceptional,
    output logic              last,
    output logic              batch_done
);

    // column occupies the low I_BITS-1 bits of a packed position
    localparam int COL_BITS = I_BITS - 1;
    localparam logic [POS_W-1:0] ROW_W      = POS_W'(1) << COL_BITS;
    localparam logic [POS_W-1:0] REGION_VEC = POS_W'(1) << L1_BITS;

    // oddness classes with special handling
    localparam logic [1:0] ODD_SAVED = 2'd0;   // walk from the saved start
    localparam logic [1:0] ODD_COL   = 2'd2;   // odd case not flagged

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,    // v0 + v1, kept for double steps
        ST_PICK,   // choose start candidate, v1 - v0 on the adder
        ST_BIAS,   // add parity bias, halve
        ST_WALK,   // one hit per cycle while the output is free
        ST_FIN     // closing result with next start
    } state_t;

    state_t                state_reg, state_next;
    logic [1:0]            odd_reg, odd_next;
    logic [POS_W-1:0]      v0_reg, v0_next;
    logic [POS_W-1:0]      v1_reg, v1_next;
    logic [POS_W-1:0]      vsum_reg, vsum_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [PIDX_W-1:0]     pidx_reg, pidx_next;
    logic                  bend_reg, bend_next;
    logic                  exc_reg, exc_next;
    logic [HIT_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [HPOS_W-1:0]     pend_pos_reg, pend_pos_next;
    logic                  pend_hv_reg, pend_hv_next;

    logic                  ov_reg, ov_next;
    logic [PIDX_W-1:0]     o_pidx_reg, o_pidx_next;
    logic [HPOS_W-1:0]     o_hpos_reg, o_hpos_next;
    logic                  o_hv_reg, o_hv_next;
    logic [POS_W-1:0]      o_ns_reg, o_ns_next;
    logic                  o_exc_reg, o_exc_next;
    logic                  o_last_reg, o_last_next;
    logic                  o_bd_reg, o_bd_next;

    // shared adder
    logic [POS_W-1:0]      add_a, add_b;
    logic                  add_cin;
    logic [POS_W:0]        add_res;

    logic [COL_BITS-1:0]   col, col0, col1;
    logic [COL_BITS:0]     col_plus0, col_plus1;
    logic                  step0, step1;
    logic                  cur_ok, nxt_ok, out_free, in_acc;
    logic                  sel_v0, sel_v1, sel_exc;

    assign add_res = {1'b0, add_a} + {1'b0, add_b} + {{POS_W{1'b0}}, add_cin};

    assign col  = pos_reg[COL_BITS-1:0];
    assign col0 = v0_reg[COL_BITS-1:0];
    assign col1 = v1_reg[COL_BITS-1:0];
    // col < ROW_W - col1  <=>  no carry into the row bits
    assign col_plus1 = {1'b0, col} + {1'b0, col1};
    assign col_plus0 = {1'b0, col} + {1'b0, col0};
    assign step0 = ~col_plus1[COL_BITS];
    assign step1 = col_plus0[COL_BITS];

    assign cur_ok = (pos_reg[POS_W-1:L1_BITS] == '0) &&
                    (cnt_reg < HIT_CNT_W'(MAX_HITS));
    assign nxt_ok = (add_res[POS_W-1:L1_BITS] == '0) &&
                    (cnt_reg < HIT_CNT_W'(MAX_HITS - 1));

    // start selection: row parity at COL_BITS, column parity at bit 0
    assign sel_v0  = (v0_reg[COL_BITS] == odd_reg[1]) && (v0_reg[0] == odd_reg[0]);
    assign sel_v1  = (v1_reg[COL_BITS] != odd_reg[1]) && (v1_reg[0] == odd_reg[0]);
    assign sel_exc = (col0 <= col1) && add_res[POS_W];  // carry of v1 - v0: v0 <= v1

    assign out_free = ~ov_reg | out_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign in_acc   = in_valid & in_ready;

    always_comb
    begin
        add_a   = pos_reg;
        add_b   = '0;
        add_cin = 1'b0;
        unique case (state_reg)
            ST_SUM:
            begin
                add_a = v0_reg;
                add_b = v1_reg;
            end
            ST_PICK:
            begin
                add_a   = v1_reg;
                add_b   = ~v0_reg;
                add_cin = 1'b1;
            end
            ST_BIAS:
            begin
                add_b = odd_reg[1] ? '0 : ROW_W;
            end
            ST_WALK:
            begin
                priority if (step0 && step1)
                    add_b = vsum_reg;
                else if (step0)
                    add_b = v0_reg;
                else if (step1)
                    add_b = v1_reg;
                else
                    add_b = '0;
            end
            ST_FIN:
            begin
                add_b   = ~REGION_VEC;
                add_cin = 1'b1;
            end
            default:
            begin
                add_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        odd_next      = cfg_wr_en ? cfg_wr_data : odd_reg;
        v0_next       = v0_reg;
        v1_next       = v1_reg;
        vsum_next     = vsum_reg;
        pos_next      = pos_reg;
        pidx_next     = pidx_reg;
        bend_next     = bend_reg;
        exc_next      = exc_reg;
        cnt_next      = cnt_reg;
        pend_pos_next = pend_pos_reg;
        pend_hv_next  = pend_hv_reg;

        ov_next     = ov_reg & ~out_ready;
        o_pidx_next = o_pidx_reg;
        o_hpos_next = o_hpos_reg;
        o_hv_next   = o_hv_reg;
        o_ns_next   = o_ns_reg;
        o_exc_next  = o_exc_reg;
        o_last_next = o_last_reg;
        o_bd_next   = o_bd_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    v0_next    = vec0;
                    v1_next    = vec1;
                    pos_next   = start_position;
                    pidx_next  = prime_index;
                    bend_next  = batch_end;
                    exc_next   = 1'b0;
                    cnt_next   = '0;
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                vsum_next  = add_res[POS_W-1:0];
                state_next = (odd_reg == ODD_SAVED) ? ST_WALK : ST_PICK;
            end
            ST_PICK:
            begin
                priority if (sel_v0)
                    pos_next = v0_reg;
                else if (sel_v1)
                    pos_next = v1_reg;
                else if (sel_exc)
                begin
                    pos_next = (col0 == col1) ? add_res[POS_W-1:0] : ROW_W;
                    exc_next = (odd_reg != ODD_COL);
                end
                else
                    pos_next = vsum_reg;
                state_next = ST_BIAS;
            end
            ST_BIAS:
            begin
                pos_next   = {1'b0, add_res[POS_W-1:1]};
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (out_free)
                begin
                    if (cur_ok)
                    begin
                        pos_next = add_res[POS_W-1:0];
                        cnt_next = cnt_reg + 1'b1;
                        if (nxt_ok)
                        begin
                            ov_next     = 1'b1;
                            o_pidx_next = pidx_reg;
                            o_hpos_next = pos_reg[HPOS_W-1:0];
                            o_hv_next   = 1'b1;
                            o_ns_next   = '0;
                            o_exc_next  = exc_reg;
                            o_last_next = 1'b0;
                            o_bd_next   = 1'b0;
                        end
                        else
                        begin
                            pend_pos_next = pos_reg[HPOS_W-1:0];
                            pend_hv_next  = 1'b1;
                            state_next    = ST_FIN;
                        end
                    end
                    else
                    begin
                        // no hit at all
                        pend_pos_next = '0;
                        pend_hv_next  = 1'b0;
                        state_next    = ST_FIN;
                    end
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    ov_next     = 1'b1;
                    o_pidx_next = pidx_reg;
                    o_hpos_next = pend_pos_reg;
                    o_hv_next   = pend_hv_reg;
                    o_ns_next   = add_res[POS_W-1:0];
                    o_exc_next  = exc_reg;
                    o_last_next = 1'b1;
                    o_bd_next   = bend_reg;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            odd_reg   <= ODD_SAVED;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            odd_reg   <= odd_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v0_reg       <= v0_next;
        v1_reg       <= v1_next;
        vsum_reg     <= vsum_next;
        pos_reg      <= pos_next;
        pidx_reg     <= pidx_next;
        bend_reg     <= bend_next;
        exc_reg      <= exc_next;
        pend_pos_reg <= pend_pos_next;
        pend_hv_reg  <= pend_hv_next;
        o_pidx_reg   <= o_pidx_next;
        o_hpos_reg   <= o_hpos_next;
        o_hv_reg     <= o_hv_next;
        o_ns_reg     <= o_ns_next;
        o_exc_reg    <= o_exc_next;
        o_last_reg   <= o_last_next;
        o_bd_reg     <= o_bd_next;
    end

    assign out_valid         = ov_reg;
    assign entry_prime_index = o_pidx_reg;
    assign hit_position      = o_hpos_reg;
    assign hit_valid         = o_hv_reg;
    assign next_start        = o_ns_reg;
    assign exceptional       = o_exc_reg;
    assign last              = o_last_reg;
    assign batch_done        = o_bd_reg;

    // hit count never passes the cap
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= HIT_CNT_W'(MAX_HITS))
        else $error("hit count above cap");

    // a result without a hit is always the closing one
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit_valid |-> last)
        else $error("empty result not last");

    // only the closing result carries batch_done
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && batch_done |-> last)
        else $error("batch_done on non-final result");

    // a taken request closes the input until the walk finishes
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input reopened during walk");

endmodule
